/* hw/rtl/fwrs_pkg.sv */
// shared constants, op codes and control/status types for the fifo with rear subtract
package fwrs_pkg;

  localparam int DATA_W       = 32;
  localparam int AMT_W        = 40;
  localparam int FILL_W       = 8;
  localparam int OP_W         = 2;
  localparam int DEF_CAPACITY = 128;
  localparam int OUT_TDATA_W  = 80;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 2'd2;

  typedef struct packed {
    logic start;
    logic sub_eval;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic sub_go;
    logic sub_more;
    logic out_free;
  } status_t;

endpackage

/* hw/rtl/fifo_with_rear_subtract_unit.sv */
// top level: fifo of signed words with push, pop and subtract from the newest entries
// m_tvalid rises via FETCH then EMIT after accept, later while a word waits
// no new word is accepted until the previous result is emitted
// subtract walks the newest entries one at a time (memory read then compare/update)
// reset (rst, synchronous): empty fifo, pointers and count cleared, no output word pending
// entry memory has no reset and needs no clearing pass
module fifo_with_rear_subtract_unit #(
  parameter int CAPACITY = fwrs_pkg::DEF_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [fwrs_pkg::DATA_W-1:0]      s_tdata,  // [31:0] operand_value
  input  logic [fwrs_pkg::OP_W-1:0]        s_tuser,  // [1:0] op
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [31:0] popped_value, [63:32] front_value, [71:64] fill_count,
  // [72] is_empty, [73] is_full, [74] push_dropped, [79:75] zero
  output logic [fwrs_pkg::OUT_TDATA_W-1:0] m_tdata
);

  fwrs_pkg::cmd_t    cmd;
  fwrs_pkg::status_t status;

  fwrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fwrs_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .op_in      (s_tuser),
    .operand_in (s_tdata),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .m_tdata    (m_tdata)
  );

endmodule

/* hw/rtl/fwrs_ctrl.sv */
// controller state machine: sequences accept, subtract walk, front fetch and result emit
module fwrs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  fwrs_pkg::status_t status,
  output fwrs_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SUB_RD = 3'd1;
  localparam logic [2:0] ST_SUB_EV = 3'd2;
  localparam logic [2:0] ST_FETCH  = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd.start    = 1'b0;
    cmd.sub_eval = 1'b0;
    cmd.emit     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = status.sub_go ? ST_SUB_RD : ST_FETCH;
        end
      end
      ST_SUB_RD: begin
        state_next = ST_SUB_EV;
      end
      ST_SUB_EV: begin
        cmd.sub_eval = 1'b1;
        state_next   = status.sub_more ? ST_SUB_RD : ST_FETCH;
      end
      ST_FETCH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/fwrs_dp.sv */
// datapath: entry memory, head/tail pointers, fill count, subtract amount and result register
module fwrs_dp #(
  parameter int CAPACITY = fwrs_pkg::DEF_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst,
  input  fwrs_pkg::cmd_t                   cmd,
  output fwrs_pkg::status_t                status,
  input  logic [fwrs_pkg::OP_W-1:0]        op_in,
  input  logic [fwrs_pkg::DATA_W-1:0]      operand_in,
  input  logic                             m_tready,
  output logic                             m_tvalid,
  output logic [fwrs_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int DW     = fwrs_pkg::DATA_W;
  // amount grows by up to one word per negative entry taken, so size it by capacity
  localparam int AW     = (DW + CNT_W > fwrs_pkg::AMT_W) ? DW + CNT_W : fwrs_pkg::AMT_W;
  localparam int FW     = fwrs_pkg::FILL_W;
  localparam int PAD_W  = fwrs_pkg::OUT_TDATA_W - 2 * DW - FW - 3;

  logic [DW-1:0]        mem [CAPACITY];
  logic [DW-1:0]        rdata_head;
  logic [DW-1:0]        rdata_tail;
  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic [DW-1:0]        wdata;

  logic [IDX_W-1:0]     head;
  logic [IDX_W-1:0]     tail;
  logic [IDX_W-1:0]     head_inc;
  logic [IDX_W-1:0]     tail_inc;
  logic [IDX_W-1:0]     tail_prev;
  logic [CNT_W-1:0]     count;
  logic signed [AW-1:0] remaining;
  logic [DW-1:0]        popped;
  logic                 dropped;

  logic                 full;
  logic                 empty;
  logic signed [AW-1:0] operand_ext;
  logic signed [AW-1:0] entry_ext;
  logic signed [AW-1:0] rem_after;
  logic signed [AW-1:0] reduced;
  logic                 take_entry;
  logic [CNT_W+FW-1:0]  count_wide;
  logic [DW-1:0]        front;

  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign head_inc  = (head == IDX_W'(CAPACITY - 1)) ? '0 : head + IDX_W'(1);
  assign tail_inc  = (tail == IDX_W'(CAPACITY - 1)) ? '0 : tail + IDX_W'(1);
  assign tail_prev = (tail == '0) ? IDX_W'(CAPACITY - 1) : tail - IDX_W'(1);

  assign operand_ext = {{(AW - DW){operand_in[DW-1]}}, operand_in};
  assign entry_ext   = {{(AW - DW){rdata_tail[DW-1]}}, rdata_tail};
  assign take_entry  = (remaining >= entry_ext);
  assign rem_after   = remaining - entry_ext;
  assign reduced     = entry_ext - remaining;

  assign status.sub_go   = (op_in == fwrs_pkg::OP_SUB) && !operand_in[DW-1]
                           && (operand_in != '0) && !empty;
  assign status.sub_more = take_entry && !rem_after[AW-1] && (rem_after != '0)
                           && (count != CNT_W'(1));
  assign status.out_free = !m_tvalid || m_tready;

  // single write port: push at accept, or shrink the newest entry at the end of a walk
  always_comb begin
    we    = 1'b0;
    waddr = tail;
    wdata = operand_in;
    if (cmd.start && (op_in == fwrs_pkg::OP_PUSH) && !full) begin
      we = 1'b1;
    end else if (cmd.sub_eval && !take_entry) begin
      we    = 1'b1;
      waddr = tail_prev;
      wdata = reduced[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_head <= mem[head];
    rdata_tail <= mem[tail_prev];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      remaining <= '0;
    end else if (cmd.start) begin
      case (op_in)
        fwrs_pkg::OP_PUSH: begin
          if (!full) begin
            tail  <= tail_inc;
            count <= count + CNT_W'(1);
          end
        end
        fwrs_pkg::OP_POP: begin
          if (!empty) begin
            head  <= head_inc;
            count <= count - CNT_W'(1);
          end
        end
        fwrs_pkg::OP_SUB: begin
          remaining <= operand_ext;
        end
        default: begin
        end
      endcase
    end else if (cmd.sub_eval) begin
      if (take_entry) begin
        tail      <= tail_prev;
        count     <= count - CNT_W'(1);
        remaining <= rem_after;
      end else begin
        remaining <= '0;
      end
    end else if (cmd.emit) begin
      remaining <= '0;
    end
  end

  // rdata_head tracks the head entry while idle, so a pop can use it at accept
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      popped  <= ((op_in == fwrs_pkg::OP_POP) && !empty) ? rdata_head : '0;
      dropped <= (op_in == fwrs_pkg::OP_PUSH) && full;
    end
  end

  assign count_wide = {{FW{1'b0}}, count};
  assign front      = empty ? '0 : rdata_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {{PAD_W{1'b0}}, dropped, full, empty, count_wide[FW-1:0], front, popped};
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_ptr_meet : assert property (@(posedge clk) disable iff (rst)
    (empty || full) |-> (head == tail))
    else $error("head and tail disagree with fill count");

  a_walk_positive : assert property (@(posedge clk) disable iff (rst)
    cmd.sub_eval |-> (!remaining[AW-1] && (remaining != '0) && !empty))
    else $error("subtract walk with no amount or no entries");

endmodule
